FILE: rtl/rmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rmf_pkg;

   // fixed field widths of the ports
   localparam int SMP_PORT_W = 16;
   localparam int MEAN_W     = 16;
   localparam int WSUM_W     = 22;
   localparam int LEN_W      = 7;

   localparam logic [LEN_W-1:0] LEN_RESET = 7'd8;

   // bits handled per cycle by the serial adder and the serial divider
   localparam int DIGIT_W = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD,
      ST_ADD,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/running_mean_filter_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                   Dir   Beat
// req       req_valid / req_ready, req_sample       in    one sample
// rsp       rsp_valid / rsp_ready, rsp_mean,        out   mean and exact window sum
//           rsp_window_sum
// csr       csr_wr_en, csr_wr_data                  in    window length, no wait
//
// A sample is taken only in the idle state, so the next one waits until the 2-bit serial adder
// and the 2-bit-per-cycle divider are through with the last one.
// Synchronous reset and every csr write empty the window (valid bits per ring slot).
// A finished result sits in the output register; a new sample is taken while it waits,
// and only the step that loads the next result stalls on rsp_ready.
module running_mean_filter_top
   import rmf_pkg::*;
#(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [SMP_PORT_W-1:0] req_sample,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [MEAN_W-1:0]      rsp_mean,
   output logic signed [WSUM_W-1:0]      rsp_window_sum,
   input  wire logic                     csr_wr_en,
   input  wire logic [LEN_W-1:0]         csr_wr_data
);

   localparam int IDX_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int CMP_W   = (IDX_W > LEN_W) ? IDX_W : LEN_W;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_MAX);
   localparam int DIG_CNT = (SUM_W + DIGIT_W - 1) / DIGIT_W;
   localparam int PW      = DIG_CNT * DIGIT_W;
   localparam int CNT_W   = (DIG_CNT > 1) ? $clog2(DIG_CNT) : 1;
   localparam int MX_W    = (PW > MEAN_W) ? PW : MEAN_W;
   localparam int SX_W    = (PW > WSUM_W) ? PW : WSUM_W;

   state_type state_ff, state_in;

   logic [LEN_W-1:0]               len_cfg_ff, len_cfg_in;
   logic [LEN_W-1:0]               len_eff;
   logic [IDX_W-1:0]               wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]               slot_ff, slot_in;
   logic [IDX_W-1:0]               slot_cur;
   logic [CMP_W:0]                 nxt_idx;
   logic signed [SAMPLE_BITS-1:0]  smp_w;
   logic signed [SAMPLE_BITS-1:0]  smp_ff, smp_in;

   logic signed [SAMPLE_BITS-1:0]  hist_mem [WINDOW_MAX];
   logic signed [SAMPLE_BITS-1:0]  hist_rd_ff;
   logic [WINDOW_MAX-1:0]          hist_vld_ff, hist_vld_in;
   logic                           rd_vld_ff, rd_vld_in;

   logic [PW-1:0]                  acc_ff, acc_in;
   logic [PW-1:0]                  neg_ff, neg_in;
   logic [PW-1:0]                  xs_ff, xs_in;
   logic [PW-1:0]                  os_ff, os_in;
   logic                           c_add_ff, c_add_in;
   logic                           c_sub_ff, c_sub_in;
   logic                           c_neg_ff, c_neg_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           sign_ff, sign_in;
   logic [DIGIT_W:0]               s_add, s_sub, s_neg;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [MEAN_W-1:0]       mean_ff, mean_in;
   logic signed [WSUM_W-1:0]       wsum_ff, wsum_in;
   logic signed [PW-1:0]           mean_full;
   logic signed [MX_W-1:0]         mean_ext;
   logic signed [SX_W-1:0]         sum_ext;

   logic                           accept;
   logic                           div_start;
   logic                           out_load;
   logic                           div_done;
   logic [PW-1:0]                  div_quo;
   logic [PW-1:0]                  div_dvd;

   // sample sign-extends from SAMPLE_BITS; wider samples take the port as unsigned
   generate
      if (SAMPLE_BITS <= SMP_PORT_W) begin : g_smp_narrow
         assign smp_w = req_sample[SAMPLE_BITS-1:0];
      end else begin : g_smp_wide
         assign smp_w = SAMPLE_BITS'($unsigned(req_sample));
      end
   endgenerate

   always_comb begin
      if (len_cfg_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (int'(len_cfg_ff) > WINDOW_MAX) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = len_cfg_ff;
      end
   end

   assign slot_cur = (CMP_W'(wr_idx_ff) >= CMP_W'(len_eff)) ? '0 : wr_idx_ff;
   assign nxt_idx  = (CMP_W + 1)'(slot_ff) + (CMP_W + 1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_READ;
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_ADD;
         ST_ADD:   if (cnt_ff == CNT_W'(DIG_CNT - 1)) state_in = ST_START;
         ST_START: state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_OUT;
         ST_OUT:   if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_START: div_start = 1'b1;
         ST_OUT:   out_load  = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign accept = req_valid && req_ready;

   // serial digit: sum + new - old, and its negation alongside
   assign s_add = {1'b0, acc_ff[DIGIT_W-1:0]} + {1'b0, xs_ff[DIGIT_W-1:0]}
                + {{DIGIT_W{1'b0}}, c_add_ff};
   assign s_sub = {1'b0, s_add[DIGIT_W-1:0]} + {1'b0, ~os_ff[DIGIT_W-1:0]}
                + {{DIGIT_W{1'b0}}, c_sub_ff};
   assign s_neg = {1'b0, ~s_sub[DIGIT_W-1:0]} + {{DIGIT_W{1'b0}}, c_neg_ff};

   assign div_dvd   = acc_ff[PW-1] ? neg_ff : acc_ff;
   assign mean_full = sign_ff ? $signed(PW'(0) - div_quo) : $signed(div_quo);
   assign mean_ext  = MX_W'(mean_full);
   assign sum_ext   = SX_W'($signed(acc_ff));

   always_comb begin
      len_cfg_in   = len_cfg_ff;
      wr_idx_in    = wr_idx_ff;
      slot_in      = slot_ff;
      smp_in       = smp_ff;
      hist_vld_in  = hist_vld_ff;
      rd_vld_in    = rd_vld_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      xs_in        = xs_ff;
      os_in        = os_ff;
      c_add_in     = c_add_ff;
      c_sub_in     = c_sub_ff;
      c_neg_in     = c_neg_ff;
      cnt_in       = cnt_ff;
      sign_in      = sign_ff;
      rsp_valid_in = rsp_valid_ff;
      mean_in      = mean_ff;
      wsum_in      = wsum_ff;

      if (accept) begin
         smp_in  = smp_w;
         slot_in = slot_cur;
      end

      if (state_ff == ST_READ) begin
         rd_vld_in = hist_vld_ff[slot_ff];
      end

      if (state_ff == ST_LOAD) begin
         xs_in    = PW'(smp_ff);
         os_in    = rd_vld_ff ? PW'(hist_rd_ff) : '0;
         c_add_in = 1'b0;
         c_sub_in = 1'b1;
         c_neg_in = 1'b1;
         cnt_in   = '0;
         hist_vld_in[slot_ff] = 1'b1;
         wr_idx_in = (nxt_idx >= (CMP_W + 1)'(len_eff)) ? '0 : nxt_idx[IDX_W-1:0];
      end

      if (state_ff == ST_ADD) begin
         acc_in   = {s_sub[DIGIT_W-1:0], acc_ff[PW-1:DIGIT_W]};
         neg_in   = {s_neg[DIGIT_W-1:0], neg_ff[PW-1:DIGIT_W]};
         xs_in    = xs_ff >> DIGIT_W;
         os_in    = os_ff >> DIGIT_W;
         c_add_in = s_add[DIGIT_W];
         c_sub_in = s_sub[DIGIT_W];
         c_neg_in = s_neg[DIGIT_W];
         cnt_in   = cnt_ff + CNT_W'(1);
      end

      if (state_ff == ST_START) begin
         sign_in = acc_ff[PW-1];
      end

      if (out_load) begin
         rsp_valid_in = 1'b1;
         mean_in      = mean_ext[MEAN_W-1:0];
         wsum_in      = sum_ext[WSUM_W-1:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // length write empties the window
      if (csr_wr_en) begin
         len_cfg_in  = csr_wr_data;
         wr_idx_in   = '0;
         acc_in      = '0;
         hist_vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_cfg_ff   <= LEN_RESET;
         wr_idx_ff    <= '0;
         acc_ff       <= '0;
         hist_vld_ff  <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_cfg_ff   <= len_cfg_in;
         wr_idx_ff    <= wr_idx_in;
         acc_ff       <= acc_in;
         hist_vld_ff  <= hist_vld_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      smp_ff    <= smp_in;
      rd_vld_ff <= rd_vld_in;
      neg_ff    <= neg_in;
      xs_ff     <= xs_in;
      os_ff     <= os_in;
      c_add_ff  <= c_add_in;
      c_sub_ff  <= c_sub_in;
      c_neg_ff  <= c_neg_in;
      sign_ff   <= sign_in;
      mean_ff   <= mean_in;
      wsum_ff   <= wsum_in;
   end

   // sample ring: read the oldest sample, then overwrite the slot
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         hist_rd_ff <= hist_mem[slot_ff];
      end
      if (state_ff == ST_LOAD) begin
         hist_mem[slot_ff] <= smp_ff;
      end
   end

   rmf_serial_div #(
      .DVD_W (PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (len_eff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean       = mean_ff;
   assign rsp_window_sum = wsum_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   a_idx_in_window: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(wr_idx_ff) < CMP_W'(len_eff))
      else $error("write index outside the window");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside the output state");

endmodule

`default_nettype wire

FILE: rtl/rmf_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned restoring divider, DIGIT_W quotient bits per cycle.
// The dividend register shifts out at the top and collects quotient bits at the bottom.
module rmf_serial_div
   import rmf_pkg::*;
#(
   parameter int DVD_W = 22
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [LEN_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   localparam int STEPS = DVD_W / DIGIT_W;
   localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic             run_ff,  run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [DVD_W-1:0] dvd_ff,  dvd_in;
   logic [LEN_W-1:0] rem_ff,  rem_in;

   logic [DVD_W-1:0] dvd_v;
   logic [LEN_W-1:0] rem_v;
   logic [LEN_W:0]   trial_v;

   // DIGIT_W chained restoring steps on narrow values
   always_comb begin
      rem_v   = rem_ff;
      dvd_v   = dvd_ff;
      trial_v = '0;
      for (int k = 0; k < DIGIT_W; k++) begin
         trial_v = {rem_v, dvd_v[DVD_W-1]};
         dvd_v   = {dvd_v[DVD_W-2:0], 1'b0};
         if (trial_v >= {1'b0, divisor}) begin
            trial_v  = trial_v - {1'b0, divisor};
            dvd_v[0] = 1'b1;
         end
         rem_v = trial_v[LEN_W-1:0];
      end
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      if (start) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         dvd_in = dvd_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

FILE: tb/sv/running_mean_filter_checker.sv
`timescale 1ns / 1ps

module running_mean_filter_checker
   import rmf_pkg::*;
#(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [SMP_PORT_W-1:0] req_sample,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [MEAN_W-1:0]     rsp_mean,
   input  logic signed [WSUM_W-1:0]     rsp_window_sum,
   input  logic                         csr_wr_en,
   input  logic [LEN_W-1:0]             csr_wr_data,
   output int                           mismatches,
   output int                           outstanding,
   output int                           beats_checked
);

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean;
      logic signed [WSUM_W-1:0] wsum;
   } mean_beat_type;

   mean_beat_type                 pending_means[$];
   logic signed [SAMPLE_BITS-1:0] ring[WINDOW_MAX];
   int                            head;
   logic signed [WSUM_W-1:0]      acc;
   logic [LEN_W-1:0]              len_reg;

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      beats_checked = 0;
   end

   function automatic void clear_window();
      for (int i = 0; i < WINDOW_MAX; i++) ring[i] = '0;
      head = 0;
      acc  = '0;
   endfunction

   // slide the window by one sample and form the expected beat
   function automatic mean_beat_type slide_window(input logic signed [SAMPLE_BITS-1:0] x);
      int            span;
      int            slot;
      longint        total;
      longint        quot;
      mean_beat_type b;
      span = (len_reg == 0) ? 1 : (len_reg > WINDOW_MAX) ? WINDOW_MAX : int'(len_reg);
      slot = (head >= span) ? 0 : head;
      total = longint'(acc) - longint'(ring[slot]) + longint'(x);
      ring[slot] = x;
      slot++;
      head = (slot >= span) ? 0 : slot;
      acc  = total[WSUM_W-1:0];
      quot = total / span;   // truncates toward zero
      b.mean = quot[MEAN_W-1:0];
      b.wsum = acc;
      return b;
   endfunction

   always @(posedge clock) begin
      mean_beat_type want;
      if (reset) begin
         clear_window();
         len_reg = LEN_RESET;
         pending_means.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_means.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, mean %0d, window sum %0d",
                        $time, rsp_mean, rsp_window_sum);
            end else begin
               want = pending_means.pop_front();
               beats_checked++;
               if (rsp_mean !== want.mean) begin
                  mismatches++;
                  $display("%0t: mean expected %0d, got %0d", $time, want.mean, rsp_mean);
               end
               if (rsp_window_sum !== want.wsum) begin
                  mismatches++;
                  $display("%0t: window sum expected %0d, got %0d",
                           $time, want.wsum, rsp_window_sum);
               end
            end
         end
         if (csr_wr_en) begin
            len_reg = csr_wr_data;
            clear_window();
         end
         if (req_valid && req_ready)
            pending_means.push_back(slide_window(req_sample[SAMPLE_BITS-1:0]));
      end
      outstanding = pending_means.size();
   end

endmodule

FILE: tb/sv/tb_running_mean_filter_top.sv
`timescale 1ns / 1ps

module tb_running_mean_filter_top;
   import rmf_pkg::*;

   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 160;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [SMP_PORT_W-1:0] req_sample;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [MEAN_W-1:0]     rsp_mean;
   logic signed [WSUM_W-1:0]     rsp_window_sum;
   logic                         csr_wr_en;
   logic [LEN_W-1:0]             csr_wr_data;

   int mismatches;
   int outstanding;
   int beats_checked;
   int samples_sent;
   int csr_writes;
   int src_quiet;
   int snk_quiet;
   int run_left;
   logic signed [SMP_PORT_W-1:0] run_val;

   running_mean_filter_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mean       (rsp_mean),
      .rsp_window_sum (rsp_window_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   running_mean_filter_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_mean       (rsp_mean),
      .rsp_window_sum (rsp_window_sum),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .beats_checked  (beats_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // idle cycles before a beat; now and then a stretch of back-to-back beats
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 29) == 0) begin
         quiet_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // mostly random samples, with full-scale runs of 2 to 71 samples, some long enough to fill any window
   function automatic logic signed [SMP_PORT_W-1:0] next_sample();
      int pick;
      if (run_left > 0) begin
         run_left--;
         return run_val;
      end
      pick = $urandom_range(0, 49);
      if (pick == 0) begin
         run_left = $urandom_range(1, 70);
         run_val  = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         return run_val;
      end else if (pick < 4) begin
         return 16'h7fff;
      end else if (pick < 7) begin
         return 16'h8000;
      end else if (pick < 14) begin
         return SMP_PORT_W'(int'($urandom_range(0, 16)) - 8);
      end
      return SMP_PORT_W'($urandom());
   endfunction

   // entered just after a rising edge; returns at the edge that takes the beat
   task automatic push_sample(input logic signed [SMP_PORT_W-1:0] s);
      int gap;
      gap = draw_gap(src_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      samples_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_len(input logic [LEN_W-1:0] v);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      csr_writes++;
   endtask

   initial begin
      int gap;
      rsp_ready = 1'b0;
      forever begin
         gap = draw_gap(snk_quiet);
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [LEN_W-1:0] lens[PHASES];
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_sample   = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      samples_sent = 0;
      csr_writes   = 0;
      src_quiet    = 0;
      snk_quiet    = 0;
      run_left     = 0;
      run_val      = '0;
      lens = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd8, 7'd0, 7'd0, 7'd0, 7'd3};
      for (int p = 8; p < 11; p++) lens[p] = LEN_W'($urandom_range(0, 127));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window of 8: zeros averaged in at first, then full scale both ways
      repeat (8) push_sample(16'h7fff);
      repeat (8) push_sample(16'h8000);
      push_sample(-16'sd1);
      push_sample(16'sd1);
      push_sample(-16'sd7);
      push_sample(16'sd7);
      push_sample(16'sd0);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         write_len(lens[p]);
         run_left = 0;
         for (int i = 0; i < ITEMS_PER_PHASE; i++) push_sample(next_sample());
      end
      settle();

      $display("Streamed %0d samples across %0d window-length writes (0, 1, 64, 127 included).",
               samples_sent, csr_writes);
      $display("Checked %0d mean/sum beats, %0d field mismatches.", beats_checked, mismatches);
      if (mismatches == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: running_mean_filter_top.f
rtl/rmf_pkg.sv
rtl/rmf_serial_div.sv
rtl/running_mean_filter_top.sv
tb/sv/running_mean_filter_checker.sv
tb/sv/tb_running_mean_filter_top.sv
